// ----- rtl/cstrip_pkg.sv -----
// ----------------------------------------------------------------------------
// cstrip_pkg
// Shared types and constants for the C comment stripper: byte codes, scan
// mode codes, status codes and the result record layout.
// ----------------------------------------------------------------------------
package cstrip_pkg;

    // Default width of the line counters
    localparam int LINE_BITS_DEF = 32;

    // Width of the error_line field
    localparam int ERR_LINE_W = 32;

    // Most records one input byte can cause
    localparam int MAX_RECS = 3;

    // Byte codes
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;

    // Scan modes
    localparam logic [2:0] MODE_TEXT       = 3'd0;
    localparam logic [2:0] MODE_TEXT_SLASH = 3'd1;
    localparam logic [2:0] MODE_TEXT_STAR  = 3'd2;
    localparam logic [2:0] MODE_LINE       = 3'd3;
    localparam logic [2:0] MODE_BLOCK      = 3'd4;
    localparam logic [2:0] MODE_BLOCK_STAR = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_STRAY_CLOSE  = 2'd1;
    localparam logic [1:0] ST_UNTERMINATED = 2'd2;

    // One result record
    typedef struct packed {
        logic [7:0]            ch;
        logic                  is_ch;
        logic [1:0]            st;
        logic [ERR_LINE_W-1:0] line;
    } rec_t;

    // Character record
    function automatic rec_t char_rec(input logic [7:0] c);
        rec_t r;
        r.ch    = c;
        r.is_ch = 1'b1;
        r.st    = ST_OK;
        r.line  = '0;
        return r;
    endfunction

    // Status record
    function automatic rec_t status_rec(input logic [1:0] s,
                                        input logic [ERR_LINE_W-1:0] ln);
        rec_t r;
        r.ch    = 8'h00;
        r.is_ch = 1'b0;
        r.st    = s;
        r.line  = ln;
        return r;
    endfunction

endpackage

// ----- rtl/c_comment_stripper.sv -----
// ----------------------------------------------------------------------------
// c_comment_stripper
// Removes // and /* */ comments from a byte stream, keeps newlines inside
// comments, counts lines and reports stray closers and open blocks.
// ----------------------------------------------------------------------------
// Usage: one byte is taken per transfer and the scan state updates in the
// same cycle, so bytes flow at one per clock as long as each byte gives at
// most one record and out_stall stays low. Records of one byte (up to
// three: a held '/' or '*', the byte itself, the final status) are loaded
// together into the output bundle register and leave one per output
// transfer; a byte that gives none loads nothing. Input stall is high
// while the bundle holds records other than the one leaving in this cycle.
// The last record of each byte carries end_of_run. After a byte marked
// last_char the block starts a new text with line one; after an error all
// bytes up to and including the next last_char are dropped without
// records.
module c_comment_stripper
    import cstrip_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            char_in,
    input  logic                  last_char,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            char_out,
    output logic                  is_char,
    output logic [1:0]            status,
    output logic [ERR_LINE_W-1:0] error_line,
    output logic                  end_of_run
);

    // Scan state
    logic [2:0]           mode_reg, mode_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [LINE_BITS-1:0] open_reg, open_next;
    logic                 failed_reg, failed_next;

    // Output bundle
    rec_t       ob_reg [MAX_RECS];
    logic [1:0] ob_cnt_reg;
    logic [1:0] ob_idx_reg;
    logic       ob_valid_reg;

    // Records made by the current byte
    rec_t       recs [MAX_RECS];
    logic [1:0] rec_n;

    logic in_xfer;
    logic out_xfer;
    logic out_done;

    // Low 32 bits of a line counter, zero-extended when narrower
    function automatic logic [ERR_LINE_W-1:0] to_err_line(input logic [LINE_BITS-1:0] v);
        logic [LINE_BITS+ERR_LINE_W-1:0] wide;
        wide = {{ERR_LINE_W{1'b0}}, v};
        return wide[ERR_LINE_W-1:0];
    endfunction

    // Next scan state and records for one byte
    always_comb
    begin
        mode_next   = mode_reg;
        line_next   = line_reg;
        open_next   = open_reg;
        failed_next = failed_reg;
        rec_n       = 2'd0;
        for (int i = 0; i < MAX_RECS; i++)
        begin
            recs[i] = char_rec(8'h00);
        end

        if (!failed_reg)
        begin
            case (mode_reg)
                MODE_TEXT_SLASH:
                begin
                    if (char_in == CH_SLASH)
                    begin
                        mode_next = MODE_LINE;
                    end
                    else if (char_in == CH_STAR)
                    begin
                        open_next = line_reg;
                        mode_next = MODE_BLOCK;
                    end
                    else
                    begin
                        recs[rec_n] = char_rec(CH_SLASH);
                        rec_n       = rec_n + 2'd1;
                        // held slash released, byte is plain text here
                        recs[rec_n] = char_rec(char_in);
                        rec_n       = rec_n + 2'd1;
                        mode_next   = MODE_TEXT;
                    end
                end
                MODE_TEXT_STAR:
                begin
                    if (char_in == CH_SLASH)
                    begin
                        recs[rec_n] = status_rec(ST_STRAY_CLOSE, to_err_line(line_reg));
                        rec_n       = rec_n + 2'd1;
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        recs[rec_n] = char_rec(CH_STAR);
                        rec_n       = rec_n + 2'd1;
                        if (char_in == CH_STAR)
                        begin
                            mode_next = MODE_TEXT_STAR;
                        end
                        else
                        begin
                            recs[rec_n] = char_rec(char_in);
                            rec_n       = rec_n + 2'd1;
                            mode_next   = MODE_TEXT;
                        end
                    end
                end
                MODE_LINE:
                begin
                    if (char_in == CH_NL)
                    begin
                        recs[rec_n] = char_rec(char_in);
                        rec_n       = rec_n + 2'd1;
                        mode_next   = MODE_TEXT;
                    end
                end
                MODE_BLOCK:
                begin
                    if (char_in == CH_STAR)
                    begin
                        mode_next = MODE_BLOCK_STAR;
                    end
                    else if (char_in == CH_NL)
                    begin
                        recs[rec_n] = char_rec(char_in);
                        rec_n       = rec_n + 2'd1;
                    end
                end
                MODE_BLOCK_STAR:
                begin
                    if (char_in == CH_SLASH)
                    begin
                        mode_next = MODE_TEXT;
                    end
                    else if (char_in != CH_STAR)
                    begin
                        if (char_in == CH_NL)
                        begin
                            recs[rec_n] = char_rec(char_in);
                            rec_n       = rec_n + 2'd1;
                        end
                        mode_next = MODE_BLOCK;
                    end
                end
                default:
                begin
                    // normal text; unused codes land here too
                    if (char_in == CH_SLASH)
                    begin
                        mode_next = MODE_TEXT_SLASH;
                    end
                    else if (char_in == CH_STAR)
                    begin
                        mode_next = MODE_TEXT_STAR;
                    end
                    else
                    begin
                        recs[rec_n] = char_rec(char_in);
                        rec_n       = rec_n + 2'd1;
                        mode_next   = MODE_TEXT;
                    end
                end
            endcase

            // line counting, wraps
            if (!failed_next && char_in == CH_NL)
            begin
                line_next = line_reg + LINE_BITS'(1);
            end

            // end of text: flush held byte, then status
            if (!failed_next && last_char)
            begin
                if (mode_next == MODE_TEXT_SLASH)
                begin
                    recs[rec_n] = char_rec(CH_SLASH);
                    rec_n       = rec_n + 2'd1;
                end
                else if (mode_next == MODE_TEXT_STAR)
                begin
                    recs[rec_n] = char_rec(CH_STAR);
                    rec_n       = rec_n + 2'd1;
                end
                if (mode_next == MODE_BLOCK || mode_next == MODE_BLOCK_STAR)
                begin
                    recs[rec_n] = status_rec(ST_UNTERMINATED, to_err_line(open_next));
                end
                else
                begin
                    recs[rec_n] = status_rec(ST_OK, '0);
                end
                rec_n = rec_n + 2'd1;
            end
        end

        // new text after the final byte
        if (last_char)
        begin
            mode_next   = MODE_TEXT;
            line_next   = LINE_BITS'(1);
            open_next   = '0;
            failed_next = 1'b0;
        end
    end

    // Handshakes
    assign out_valid = ob_valid_reg;
    assign end_of_run = (ob_idx_reg == ob_cnt_reg - 2'd1);
    assign out_xfer  = ob_valid_reg && !out_stall;
    assign out_done  = out_xfer && end_of_run;
    assign in_stall  = ob_valid_reg && !out_done;
    assign in_xfer   = in_valid && !in_stall;

    // Current record
    assign char_out   = ob_reg[ob_idx_reg].ch;
    assign is_char    = ob_reg[ob_idx_reg].is_ch;
    assign status     = ob_reg[ob_idx_reg].st;
    assign error_line = ob_reg[ob_idx_reg].line;

    // Scan state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_TEXT;
            line_reg   <= LINE_BITS'(1);
            open_reg   <= '0;
            failed_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            mode_reg   <= mode_next;
            line_reg   <= line_next;
            open_reg   <= open_next;
            failed_reg <= failed_next;
        end
    end

    // Output bundle control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_valid_reg <= 1'b0;
            ob_cnt_reg   <= 2'd0;
            ob_idx_reg   <= 2'd0;
        end
        else if (in_xfer && rec_n != 2'd0)
        begin
            ob_valid_reg <= 1'b1;
            ob_cnt_reg   <= rec_n;
            ob_idx_reg   <= 2'd0;
        end
        else if (out_done)
        begin
            ob_valid_reg <= 1'b0;
            ob_idx_reg   <= 2'd0;
        end
        else if (out_xfer)
        begin
            ob_idx_reg <= ob_idx_reg + 2'd1;
        end
    end

    // Output bundle payload
    always_ff @(posedge clk)
    begin
        if (in_xfer && rec_n != 2'd0)
        begin
            for (int i = 0; i < MAX_RECS; i++)
            begin
                ob_reg[i] <= recs[i];
            end
        end
    end

    // Checks
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ob_valid_reg |-> (ob_idx_reg < ob_cnt_reg))
        else $error("bundle index past record count");

    a_silent_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && failed_reg) |-> (rec_n == 2'd0))
        else $error("record made after an error");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ob_valid_reg && !is_char) |-> end_of_run)
        else $error("status record not last of its byte");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && last_char) |=> (mode_reg == MODE_TEXT && !failed_reg))
        else $error("scan state not cleared after final byte");

    a_final_status: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && last_char && !failed_reg) |=>
            (ob_valid_reg && !ob_reg[ob_cnt_reg - 2'd1].is_ch))
        else $error("final byte gave no status record");

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for c_comment_stripper. A built-in scanner model
// predicts the records of every byte transfer; a monitor compares each
// output transfer field by field. Directed texts cover the comment forms
// and error cases, then random texts run under several idle/stall mixes
// and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import cstrip_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 500;
    localparam int SETTLE_CYCLES = 8;

    // one expected output transfer
    typedef struct {
        logic [7:0]            ch;
        logic                  is_ch;
        logic [1:0]            st;
        logic [ERR_LINE_W-1:0] line;
        logic                  eor;
    } strip_rec_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [7:0]            char_in    = 8'h00;
    logic                  last_char  = 1'b0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [7:0]            char_out;
    logic                  is_char;
    logic [1:0]            status;
    logic [ERR_LINE_W-1:0] error_line;
    logic                  end_of_run;

    // expected records, oldest first
    strip_rec_t expected_recs[$];
    int         fail_count    = 0;
    int         cycle_count   = 0;
    int         live_items    = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_left     = 0;

    // scanner model state
    logic [2:0]            scan_st;
    logic [31:0]           cur_line;
    logic [31:0]           opener_line;
    logic                  aborted;
    strip_rec_t            byte_recs[$];

    c_comment_stripper DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_in    (char_in),
        .last_char  (last_char),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .char_out   (char_out),
        .is_char    (is_char),
        .status     (status),
        .error_line (error_line),
        .end_of_run (end_of_run)
    );

    // clock, period 8
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("c_comment_stripper: mismatch");
            $finish;
        end
    end

    // receiver: long hold-off when requested, else random stalls
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ---------------- scanner model ----------------

    function automatic strip_rec_t make_rec(input logic [7:0] c, input logic ischr,
                                            input logic [1:0] s,
                                            input logic [ERR_LINE_W-1:0] ln);
        strip_rec_t r;
        r.ch    = c;
        r.is_ch = ischr;
        r.st    = s;
        r.line  = ln;
        r.eor   = 1'b0;
        return r;
    endfunction

    function automatic void clear_scan();
        scan_st     = MODE_TEXT;
        cur_line    = 32'd1;
        opener_line = 32'd0;
        aborted     = 1'b0;
    endfunction

    // plain text byte: hold marks, pass everything else
    function automatic void scan_plain(input logic [7:0] c);
        if (c == CH_SLASH)
            scan_st = MODE_TEXT_SLASH;
        else if (c == CH_STAR)
            scan_st = MODE_TEXT_STAR;
        else
        begin
            byte_recs.push_back(make_rec(c, 1'b1, ST_OK, '0));
            scan_st = MODE_TEXT;
        end
    endfunction

    // records caused by one accepted byte, appended to expected_recs
    function automatic void predict_strip(input logic [7:0] c, input logic lst);
        byte_recs.delete();
        if (!aborted)
        begin
            live_items++;
            case (scan_st)
                MODE_TEXT_SLASH:
                begin
                    if (c == CH_SLASH)
                        scan_st = MODE_LINE;
                    else if (c == CH_STAR)
                    begin
                        opener_line = cur_line;
                        scan_st     = MODE_BLOCK;
                    end
                    else
                    begin
                        byte_recs.push_back(make_rec(CH_SLASH, 1'b1, ST_OK, '0));
                        scan_plain(c);
                    end
                end
                MODE_TEXT_STAR:
                begin
                    if (c == CH_SLASH)
                    begin
                        byte_recs.push_back(make_rec(8'h00, 1'b0, ST_STRAY_CLOSE,
                                                     cur_line));
                        aborted = 1'b1;
                    end
                    else
                    begin
                        byte_recs.push_back(make_rec(CH_STAR, 1'b1, ST_OK, '0));
                        scan_plain(c);
                    end
                end
                MODE_LINE:
                begin
                    if (c == CH_NL)
                    begin
                        byte_recs.push_back(make_rec(c, 1'b1, ST_OK, '0));
                        scan_st = MODE_TEXT;
                    end
                end
                MODE_BLOCK:
                begin
                    if (c == CH_STAR)
                        scan_st = MODE_BLOCK_STAR;
                    else if (c == CH_NL)
                        byte_recs.push_back(make_rec(c, 1'b1, ST_OK, '0));
                end
                MODE_BLOCK_STAR:
                begin
                    if (c == CH_SLASH)
                        scan_st = MODE_TEXT;
                    else if (c != CH_STAR)
                    begin
                        if (c == CH_NL)
                            byte_recs.push_back(make_rec(c, 1'b1, ST_OK, '0));
                        scan_st = MODE_BLOCK;
                    end
                end
                default:
                    scan_plain(c);
            endcase

            if (!aborted && c == CH_NL)
                cur_line = cur_line + 32'd1;

            // end of text: flush a held mark, then the status record
            if (!aborted && lst)
            begin
                if (scan_st == MODE_TEXT_SLASH)
                    byte_recs.push_back(make_rec(CH_SLASH, 1'b1, ST_OK, '0));
                else if (scan_st == MODE_TEXT_STAR)
                    byte_recs.push_back(make_rec(CH_STAR, 1'b1, ST_OK, '0));
                if (scan_st == MODE_BLOCK || scan_st == MODE_BLOCK_STAR)
                    byte_recs.push_back(make_rec(8'h00, 1'b0, ST_UNTERMINATED,
                                                 opener_line));
                else
                    byte_recs.push_back(make_rec(8'h00, 1'b0, ST_OK, '0));
            end
        end

        if (lst)
            clear_scan();

        for (int i = 0; i < byte_recs.size(); i++)
        begin
            if (i == byte_recs.size() - 1)
                byte_recs[i].eor = 1'b1;
            expected_recs.push_back(byte_recs[i]);
        end
    endfunction

    // ---------------- output checker ----------------

    always @(posedge clk)
    begin : check_out
        strip_rec_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_recs.size() == 0)
            begin
                $error("unexpected record: char_out %0h is_char %0b status %0d line %0d",
                       char_out, is_char, status, error_line);
                fail_count++;
            end
            else
            begin
                want = expected_recs.pop_front();
                if (char_out !== want.ch)
                begin
                    $error("char_out: expected %0h, actual %0h", want.ch, char_out);
                    fail_count++;
                end
                if (is_char !== want.is_ch)
                begin
                    $error("is_char: expected %0b, actual %0b", want.is_ch, is_char);
                    fail_count++;
                end
                if (status !== want.st)
                begin
                    $error("status: expected %0d, actual %0d", want.st, status);
                    fail_count++;
                end
                if (error_line !== want.line)
                begin
                    $error("error_line: expected %0d, actual %0d", want.line, error_line);
                    fail_count++;
                end
                if (end_of_run !== want.eor)
                begin
                    $error("end_of_run: expected %0b, actual %0b", want.eor, end_of_run);
                    fail_count++;
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    // one byte transfer; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] c, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        char_in   <= c;
        last_char <= lst;
        do
            @(posedge clk);
        while (in_stall);
        predict_strip(c, lst);
        @(negedge clk);
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_recs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // often newlines and marks, else any byte
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(9);
        if (r < 2)
            return CH_NL;
        else if (r == 2)
            return CH_SLASH;
        else if (r == 3)
            return CH_STAR;
        return 8'($urandom_range(255));
    endfunction

    // random text built from comment forms with random content
    function automatic void build_text(ref logic [7:0] txt[$]);
        int ntok;
        int r;
        txt.delete();
        ntok = $urandom_range(6, 1);
        for (int t = 0; t < ntok; t++)
        begin
            r = $urandom_range(99);
            if (r < 40)
            begin
                repeat ($urandom_range(4, 1)) txt.push_back(pick_byte());
            end
            else if (r < 62)
            begin
                txt.push_back(CH_SLASH);
                txt.push_back(CH_SLASH);
                repeat ($urandom_range(5)) txt.push_back(8'($urandom_range(255)));
                if ($urandom_range(9) < 8)
                    txt.push_back(CH_NL);
            end
            else if (r < 88)
            begin
                txt.push_back(CH_SLASH);
                txt.push_back(CH_STAR);
                repeat ($urandom_range(6)) txt.push_back(pick_byte());
                if ($urandom_range(9) < 9)
                begin
                    txt.push_back(CH_STAR);
                    txt.push_back(CH_SLASH);
                end
            end
            else if (r < 92)
            begin
                txt.push_back(CH_STAR);
                txt.push_back(CH_SLASH);
            end
            else
            begin
                repeat ($urandom_range(3, 1)) txt.push_back(8'($urandom_range(255)));
            end
        end
    endfunction

    task automatic send_random_texts(input int n_items);
        logic [7:0] txt[$];
        int         goal;
        goal = live_items + n_items;
        while (live_items < goal)
        begin
            build_text(txt);
            for (int i = 0; i < txt.size(); i++)
                send_byte(txt[i], i == txt.size() - 1);
        end
    endtask

    // ---------------- tests ----------------

    // all-zero and all-one bytes pass through
    task automatic test_byte_extremes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_idle();
    endtask

    // held slash and star followed by other bytes, star held at end
    task automatic test_held_marks();
        send_str("/x*y*");
        wait_idle();
    endtask

    // line comments keep their newline; open line comment and held slash at end
    task automatic test_line_comment();
        send_str("//\n//");
        send_str("/");
        wait_idle();
    endtask

    // slash-star-slash stays open, newline kept, double star closes; then open at end
    task automatic test_block_comment();
        send_str("/*/\n**/");
        send_str("\n/*");
        wait_idle();
    endtask

    // stray closer reports the line and drops the rest of the text
    task automatic test_stray_close();
        send_str("*/x");
        send_str("q");
        wait_idle();
    endtask

    task automatic test_random_mix(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        send_random_texts(RANDOM_ITEMS / 4);
        wait_idle();
    endtask

    // output held off for a long stretch while bytes keep coming
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 120;
        send_random_texts(40);
        wait_idle();
    endtask

    initial
    begin
        clear_scan();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_byte_extremes();
        test_held_marks();
        test_line_comment();
        test_block_comment();
        test_stray_close();
        test_random_mix(0, 0);
        test_random_mix(84, 0);
        test_random_mix(0, 84);
        test_random_mix(12, 12);
        test_backpressure();

        if (fail_count == 0 && expected_recs.size() == 0)
            $display("c_comment_stripper: match");
        else
            $display("c_comment_stripper: mismatch");
        $finish;
    end

endmodule
